>>> src/srt_pkg.sv
// Shared constants and controller/datapath interface types for the segment reassembly tracker
package srt_pkg;

   localparam int SLOTS_DEFAULT     = 4;
   localparam int MAX_PARTS_DEFAULT = 16;

   localparam int TIMEOUT_W                   = 22;
   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 22'd60000;

   localparam logic [1:0] RK_PASS    = 2'd0;
   localparam logic [1:0] RK_DONE    = 2'd1;
   localparam logic [1:0] RK_TIMEOUT = 2'd2;

   localparam logic KIND_SEGMENT = 1'b0;
   localparam logic KIND_SWEEP   = 1'b1;

   typedef struct packed {
      logic load;        // capture the input word, rewind the slot walk
      logic scan;        // look at one slot for match, free entry and oldest start
      logic sweep_scan;  // look at one slot for age against the timeout
      logic update;      // store the part into the chosen slot
      logic emit_pass;   // send the segment straight through
      logic emit_done;   // send the completed slot and free it
      logic emit_sweep;  // send the lowest expired slot and free it
   } srt_cmd_type;

   typedef struct packed {
      logic kind_sweep;
      logic seg_multi;
      logic idx_last;
      logic complete;
      logic any_due;
      logic out_free;
   } srt_sts_type;

endpackage

>>> src/srt_ctrl.sv
// Sequencer for the segment reassembly tracker
module srt_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  srt_pkg::srt_sts_type sts,
   output srt_pkg::srt_cmd_type cmd
);
   import srt_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_SEG_SCAN,
      ST_SEG_UPDATE,
      ST_SEG_CHECK,
      ST_PASS,
      ST_SWEEP_SCAN,
      ST_SWEEP_EMIT
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            if (sts.kind_sweep) begin
               state_in = ST_SWEEP_SCAN;
            end else if (sts.seg_multi) begin
               state_in = ST_SEG_SCAN;
            end else begin
               state_in = ST_PASS;
            end
         end
         ST_SEG_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.idx_last) begin
               state_in = ST_SEG_UPDATE;
            end
         end
         ST_SEG_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = ST_SEG_CHECK;
         end
         ST_SEG_CHECK: begin
            if (!sts.complete) begin
               state_in = ST_IDLE;
            end else if (sts.out_free) begin
               cmd.emit_done = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         ST_PASS: begin
            if (sts.out_free) begin
               cmd.emit_pass = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         ST_SWEEP_SCAN: begin
            cmd.sweep_scan = 1'b1;
            if (sts.idx_last) begin
               state_in = ST_SWEEP_EMIT;
            end
         end
         ST_SWEEP_EMIT: begin
            // drain expired slots one word at a time
            if (!sts.any_due) begin
               state_in = ST_IDLE;
            end else if (sts.out_free) begin
               cmd.emit_sweep = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> src/srt_dpath.sv
// Slot table, scan accumulators, timeout register and result register
module srt_dpath #(
   parameter int SLOTS     = srt_pkg::SLOTS_DEFAULT,
   parameter int MAX_PARTS = srt_pkg::MAX_PARTS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  srt_pkg::srt_cmd_type          cmd,
   output srt_pkg::srt_sts_type          sts,
   input  logic                          req_kind,
   input  logic [31:0]                   req_now_ms,
   input  logic [15:0]                   req_msg_ref,
   input  logic [31:0]                   req_sender_tag,
   input  logic [7:0]                    req_seg_total,
   input  logic [7:0]                    req_part_number,
   input  logic [31:0]                   req_msg_time,
   input  logic                          csr_wr_en,
   input  logic [srt_pkg::TIMEOUT_W-1:0] csr_wr_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [1:0]                    rsp_result_kind,
   output logic [1:0]                    rsp_slot_index,
   output logic [15:0]                   rsp_out_ref,
   output logic [31:0]                   rsp_out_sender,
   output logic [31:0]                   rsp_out_time,
   output logic [7:0]                    rsp_out_total,
   output logic [15:0]                   rsp_parts_present,
   output logic [4:0]                    rsp_parts_count,
   output logic                          rsp_last
);
   import srt_pkg::*;

   localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int PW = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1;
   localparam int CW = $clog2(MAX_PARTS + 1);

   // slot table: only the busy bits need reset, a taken slot rewrites every field
   logic                 slot_busy_ff   [SLOTS];
   logic [15:0]          slot_ref_ff    [SLOTS];
   logic [31:0]          slot_sender_ff [SLOTS];
   logic [7:0]           slot_total_ff  [SLOTS];
   logic [CW-1:0]        slot_count_ff  [SLOTS];
   logic [31:0]          slot_start_ff  [SLOTS];
   logic [31:0]          slot_stamp_ff  [SLOTS];
   logic [MAX_PARTS-1:0] slot_mask_ff   [SLOTS];

   logic [TIMEOUT_W-1:0] timeout_ff;

   // captured input word
   logic        item_kind_ff;
   logic [31:0] item_now_ff;
   logic [15:0] item_ref_ff;
   logic [31:0] item_sender_ff;
   logic [7:0]  item_total_ff;
   logic [7:0]  item_part_ff;
   logic [31:0] item_time_ff;

   // walk state
   logic [IW-1:0]    idx_ff;
   logic [IW-1:0]    idx_in;
   logic             match_found_ff;
   logic [IW-1:0]    match_idx_ff;
   logic             free_found_ff;
   logic [IW-1:0]    free_idx_ff;
   logic [31:0]      min_start_ff;
   logic [IW-1:0]    min_idx_ff;
   logic [IW-1:0]    pick_ff;
   logic             complete_ff;
   logic             complete_in;
   logic [SLOTS-1:0] due_ff;

   // result register
   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   logic [1:0]  rsp_kind_ff;
   logic [1:0]  rsp_slot_ff;
   logic [15:0] rsp_ref_ff;
   logic [31:0] rsp_sender_ff;
   logic [31:0] rsp_time_ff;
   logic [7:0]  rsp_total_ff;
   logic [15:0] rsp_mask_ff;
   logic [4:0]  rsp_count_ff;
   logic        rsp_last_ff;

   // single read port of the table
   logic [IW-1:0]        pick_c;
   logic [IW-1:0]        sel_c;
   logic [IW-1:0]        rd_idx;
   logic                 rd_busy;
   logic [15:0]          rd_ref;
   logic [31:0]          rd_sender;
   logic [7:0]           rd_total;
   logic [CW-1:0]        rd_count;
   logic [31:0]          rd_start;
   logic [31:0]          rd_stamp;
   logic [MAX_PARTS-1:0] rd_mask;

   logic                 rd_match;
   logic [31:0]          age_c;
   logic                 due_c;
   logic                 sweep_last_c;

   logic [MAX_PARTS-1:0] base_mask;
   logic [CW-1:0]        base_count;
   logic [31:0]          base_stamp;
   logic [7:0]           total_use;
   logic [PW-1:0]        pidx;
   logic                 in_range;
   logic                 fresh;
   logic [MAX_PARTS-1:0] new_mask;
   logic [CW-1:0]        new_count;
   logic [31:0]          new_stamp;

   assign pick_c = match_found_ff ? match_idx_ff :
                   (free_found_ff ? free_idx_ff : min_idx_ff);

   // lowest pending expired slot
   always_comb begin
      sel_c = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (due_ff[i]) begin
            sel_c = IW'(i);
         end
      end
   end

   assign sweep_last_c = ((due_ff & ~(SLOTS'(1) << sel_c)) == '0);

   always_comb begin
      if (cmd.update) begin
         rd_idx = pick_c;
      end else if (cmd.emit_done) begin
         rd_idx = pick_ff;
      end else if (cmd.emit_sweep) begin
         rd_idx = sel_c;
      end else begin
         rd_idx = idx_ff;
      end
   end

   assign rd_busy   = slot_busy_ff[rd_idx];
   assign rd_ref    = slot_ref_ff[rd_idx];
   assign rd_sender = slot_sender_ff[rd_idx];
   assign rd_total  = slot_total_ff[rd_idx];
   assign rd_count  = slot_count_ff[rd_idx];
   assign rd_start  = slot_start_ff[rd_idx];
   assign rd_stamp  = slot_stamp_ff[rd_idx];
   assign rd_mask   = slot_mask_ff[rd_idx];

   assign rd_match = rd_busy && (rd_ref == item_ref_ff) && (rd_sender == item_sender_ff);
   assign age_c    = item_now_ff - rd_start;
   assign due_c    = rd_busy && (age_c >= 32'(timeout_ff));

   // part merge into the chosen slot; a fresh slot starts empty
   assign base_mask  = match_found_ff ? rd_mask  : '0;
   assign base_count = match_found_ff ? rd_count : '0;
   assign base_stamp = match_found_ff ? rd_stamp : 32'd0;
   assign total_use  = match_found_ff ? rd_total : item_total_ff;
   assign pidx       = PW'(item_part_ff - 8'd1);
   assign in_range   = (item_part_ff <= 8'(MAX_PARTS));
   assign fresh      = in_range && !base_mask[pidx];
   assign new_mask   = fresh ? (base_mask | (MAX_PARTS'(1) << pidx)) : base_mask;
   assign new_count  = fresh ? (base_count + CW'(1)) : base_count;
   assign new_stamp  = (fresh && (base_count == '0)) ? item_time_ff : base_stamp;
   assign complete_in = (8'(new_count) >= total_use);

   // rewind on load, advance during a walk, wrap after the last slot
   assign idx_in = cmd.load ? '0 :
                   ((cmd.scan || cmd.sweep_scan) ?
                    (sts.idx_last ? '0 : idx_ff + IW'(1)) : idx_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            slot_busy_ff[i] <= 1'b0;
         end
      end else begin
         if (cmd.update) begin
            slot_busy_ff[pick_c] <= 1'b1;
         end
         if (cmd.emit_done || cmd.emit_sweep) begin
            slot_busy_ff[rd_idx] <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         slot_ref_ff[pick_c]    <= item_ref_ff;
         slot_sender_ff[pick_c] <= item_sender_ff;
         slot_total_ff[pick_c]  <= total_use;
         slot_count_ff[pick_c]  <= new_count;
         slot_stamp_ff[pick_c]  <= new_stamp;
         slot_mask_ff[pick_c]   <= new_mask;
         if (!match_found_ff) begin
            slot_start_ff[pick_c] <= item_now_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TIMEOUT_RESET;
      end else if (csr_wr_en) begin
         timeout_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         item_kind_ff   <= req_kind;
         item_now_ff    <= req_now_ms;
         item_ref_ff    <= req_msg_ref;
         item_sender_ff <= req_sender_tag;
         item_total_ff  <= req_seg_total;
         item_part_ff   <= req_part_number;
         item_time_ff   <= req_msg_time;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff         <= '0;
         match_found_ff <= 1'b0;
         free_found_ff  <= 1'b0;
         complete_ff    <= 1'b0;
         due_ff         <= '0;
      end else begin
         idx_ff <= idx_in;
         if (cmd.load) begin
            match_found_ff <= 1'b0;
            free_found_ff  <= 1'b0;
            complete_ff    <= 1'b0;
            due_ff         <= '0;
         end
         if (cmd.scan) begin
            if (rd_match && !match_found_ff) begin
               match_found_ff <= 1'b1;
            end
            if (!rd_busy && !free_found_ff) begin
               free_found_ff <= 1'b1;
            end
         end
         if (cmd.sweep_scan) begin
            due_ff[idx_ff] <= due_c;
         end
         if (cmd.emit_sweep) begin
            due_ff[sel_c] <= 1'b0;
         end
         if (cmd.update) begin
            complete_ff <= complete_in;
         end
         if (cmd.emit_done) begin
            complete_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan) begin
         if (rd_match && !match_found_ff) begin
            match_idx_ff <= idx_ff;
         end
         if (!rd_busy && !free_found_ff) begin
            free_idx_ff <= idx_ff;
         end
         // oldest start: strict less keeps the lowest index on a tie
         if ((idx_ff == '0) || (rd_start < min_start_ff)) begin
            min_start_ff <= rd_start;
            min_idx_ff   <= idx_ff;
         end
      end
      if (cmd.update) begin
         pick_ff <= pick_c;
      end
   end

   // result register: load when empty or being taken, hold under stall
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.emit_pass || cmd.emit_done || cmd.emit_sweep) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_pass) begin
         rsp_kind_ff   <= RK_PASS;
         rsp_slot_ff   <= 2'd0;
         rsp_ref_ff    <= item_ref_ff;
         rsp_sender_ff <= item_sender_ff;
         rsp_time_ff   <= item_time_ff;
         rsp_total_ff  <= item_total_ff;
         rsp_mask_ff   <= 16'd0;
         rsp_count_ff  <= 5'd0;
         rsp_last_ff   <= 1'b1;
      end else if (cmd.emit_done || cmd.emit_sweep) begin
         rsp_kind_ff   <= cmd.emit_done ? RK_DONE : RK_TIMEOUT;
         rsp_slot_ff   <= 2'(rd_idx);
         rsp_ref_ff    <= rd_ref;
         rsp_sender_ff <= rd_sender;
         rsp_time_ff   <= rd_stamp;
         rsp_total_ff  <= rd_total;
         rsp_mask_ff   <= 16'(rd_mask);
         rsp_count_ff  <= 5'(rd_count);
         rsp_last_ff   <= cmd.emit_done ? 1'b1 : sweep_last_c;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_result_kind   = rsp_kind_ff;
   assign rsp_slot_index    = rsp_slot_ff;
   assign rsp_out_ref       = rsp_ref_ff;
   assign rsp_out_sender    = rsp_sender_ff;
   assign rsp_out_time      = rsp_time_ff;
   assign rsp_out_total     = rsp_total_ff;
   assign rsp_parts_present = rsp_mask_ff;
   assign rsp_parts_count   = rsp_count_ff;
   assign rsp_last          = rsp_last_ff;

   assign sts.kind_sweep = (item_kind_ff == KIND_SWEEP);
   assign sts.seg_multi  = (item_total_ff > 8'd1) && (item_part_ff != 8'd0);
   assign sts.idx_last   = (idx_ff == IW'(SLOTS - 1));
   assign sts.complete   = complete_ff;
   assign sts.any_due    = (due_ff != '0);
   assign sts.out_free   = !rsp_valid_ff || !rsp_stall;

endmodule

>>> src/segment_reassembly_tracker.sv
// Top level of the segment reassembly tracker: sequencer, datapath and checks
//
// Collects multi-part message segments in a table of SLOTS entries and emits a
// word when a message completes, passes single segments and segments with part
// number 0 straight through, and on a sweep word flushes every entry whose age
// has reached timeout_ms. One input word is worked at a time, the slot table
// being walked one entry per cycle through a single compare unit. The result
// register lets a new input word be taken while the last result still waits on
// rsp_stall. A sweep that flushes several entries sends them in slot order with
// rsp_last on the final one. The user is to write timeout_ms through
// csr_wr_en/csr_wr_data only while the block is idle; the block itself does
// not enforce this. timeout_ms resets to 60000.
module segment_reassembly_tracker #(
   parameter int SLOTS     = srt_pkg::SLOTS_DEFAULT,
   parameter int MAX_PARTS = srt_pkg::MAX_PARTS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_kind,
   input  logic [31:0]                   req_now_ms,
   input  logic [15:0]                   req_msg_ref,
   input  logic [31:0]                   req_sender_tag,
   input  logic [7:0]                    req_seg_total,
   input  logic [7:0]                    req_part_number,
   input  logic [31:0]                   req_msg_time,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [1:0]                    rsp_result_kind,
   output logic [1:0]                    rsp_slot_index,
   output logic [15:0]                   rsp_out_ref,
   output logic [31:0]                   rsp_out_sender,
   output logic [31:0]                   rsp_out_time,
   output logic [7:0]                    rsp_out_total,
   output logic [15:0]                   rsp_parts_present,
   output logic [4:0]                    rsp_parts_count,
   output logic                          rsp_last,
   input  logic                          csr_wr_en,
   input  logic [srt_pkg::TIMEOUT_W-1:0] csr_wr_data
);
   import srt_pkg::*;

   srt_cmd_type cmd;
   srt_sts_type sts;

   srt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   srt_dpath #(
      .SLOTS     (SLOTS),
      .MAX_PARTS (MAX_PARTS)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_kind          (req_kind),
      .req_now_ms        (req_now_ms),
      .req_msg_ref       (req_msg_ref),
      .req_sender_tag    (req_sender_tag),
      .req_seg_total     (req_seg_total),
      .req_part_number   (req_part_number),
      .req_msg_time      (req_msg_time),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_result_kind   (rsp_result_kind),
      .rsp_slot_index    (rsp_slot_index),
      .rsp_out_ref       (rsp_out_ref),
      .rsp_out_sender    (rsp_out_sender),
      .rsp_out_time      (rsp_out_time),
      .rsp_out_total     (rsp_out_total),
      .rsp_parts_present (rsp_parts_present),
      .rsp_parts_count   (rsp_parts_count),
      .rsp_last          (rsp_last)
   );

   // a taken word keeps the input side closed until its work is done
   a_one_word: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input taken while a word was still in work");

   // an idle block with an empty result register cannot produce a word
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      (!req_stall && !rsp_valid) |=> !rsp_valid)
      else $error("result appeared with no word in work");

   a_pass_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_result_kind == RK_PASS)) |->
      (rsp_last && (rsp_parts_count == 5'd0) && (rsp_parts_present == 16'd0) &&
       (rsp_slot_index == 2'd0)))
      else $error("passthrough result carries slot data");

   a_done_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_result_kind == RK_DONE)) |-> rsp_last)
      else $error("completed message not marked last");

endmodule
